// ===== design/kpl_pkg.sv =====
`default_nettype none

package kpl_pkg;

	// Input item kinds, carried on the slave tuser bit
	typedef enum logic {
		OP_KEY  = 1'b0,
		OP_TICK = 1'b1
	} kpl_op_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_INCOMPLETE    = 3'd1,
		ST_INVALID       = 3'd2,
		ST_VALID         = 3'd3,
		ST_COOLDOWN      = 3'd4,
		ST_REQUIRE_RESET = 3'd5
	} kpl_status_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SECRET       = 3'd0,
		REG_MAX_ATTEMPTS = 3'd1,
		REG_COOLDOWN     = 3'd2,
		REG_POP_KEY      = 3'd3,
		REG_VALIDATE_KEY = 3'd4
	} kpl_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_NINE = 8'h39;

	// Digits held by the secret register
	localparam int unsigned SECRET_DIGITS = 4;

	localparam logic [15:0] SECRET_RST       = 16'd0;
	localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
	localparam logic [31:0] COOLDOWN_RST     = 32'd30;
	localparam logic [7:0]  POP_KEY_RST      = 8'd42;
	localparam logic [7:0]  VALIDATE_KEY_RST = 8'd35;

	typedef struct packed {
		logic [15:0] secret_digits;
		logic [7:0]  max_attempts;
		logic [31:0] cooldown_ticks;
		logic [7:0]  pop_key;
		logic [7:0]  validate_key;
	} kpl_cfg_t;

	typedef struct packed {
		logic [7:0]  fail_count;
		logic        cooldown_active;
		logic        locked;
		logic [2:0]  entered_count;
		kpl_status_t status;
	} kpl_result_t;

endpackage

`default_nettype wire

// ===== design/kpl_core.sv =====
`default_nettype none

module kpl_core #(
	parameter int unsigned CODE_DIGITS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kpl_pkg::kpl_cfg_t cfg,
	input  wire logic              step,
	input  wire kpl_pkg::kpl_op_t  op,
	input  wire logic [7:0]        key_code,
	output kpl_pkg::kpl_result_t   result
);

	localparam int unsigned CW = $clog2(CODE_DIGITS + 1);

	logic [3:0]    entry_q [CODE_DIGITS];
	logic [CW-1:0] count_q;
	logic [7:0]    fail_q;
	logic          started_q;
	logic [31:0]   elapsed_q;
	logic          lockout_q;

	logic [CW-1:0] count_d;
	logic [7:0]    fail_d;
	logic          started_d;
	logic [31:0]   elapsed_d;
	logic          lockout_d;
	logic          digit_we;
	logic [3:0]    digit_val;

	logic [CODE_DIGITS-1:0] digit_hit;
	logic                   match;
	logic                   running;
	logic                   is_digit;
	logic [7:0]             fail_inc;
	kpl_pkg::kpl_status_t   status;

	// Compare each held digit with its secret nibble, or with zero past the secret's digits
	for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_cmp
		if (i < kpl_pkg::SECRET_DIGITS) begin : g_sec
			assign digit_hit[i] = (entry_q[i] == cfg.secret_digits[4*i +: 4]);
		end else begin : g_zero
			assign digit_hit[i] = (entry_q[i] == 4'd0);
		end
	end

	assign match     = &digit_hit;
	assign running   = started_q && (elapsed_q < cfg.cooldown_ticks);
	assign is_digit  = (key_code >= kpl_pkg::KEY_ZERO) && (key_code <= kpl_pkg::KEY_NINE);
	assign fail_inc  = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
	assign digit_val = 4'(key_code - kpl_pkg::KEY_ZERO);

	always_comb begin
		count_d   = count_q;
		fail_d    = fail_q;
		started_d = started_q;
		elapsed_d = elapsed_q;
		lockout_d = lockout_q;
		digit_we  = 1'b0;
		status    = kpl_pkg::ST_OK;
		if (op == kpl_pkg::OP_TICK) begin
			if (running) begin
				elapsed_d = elapsed_q + 32'd1;
			end
		end else if (lockout_q) begin
			status = kpl_pkg::ST_REQUIRE_RESET;
		end else if (running) begin
			count_d = '0;
			status  = kpl_pkg::ST_COOLDOWN;
		end else if (key_code == cfg.pop_key) begin
			if (count_q != '0) begin
				count_d = count_q - CW'(1);
			end
		end else if (key_code == cfg.validate_key) begin
			if (count_q != CW'(CODE_DIGITS)) begin
				status = kpl_pkg::ST_INCOMPLETE;
			end else begin
				count_d = '0;
				if (match) begin
					fail_d    = 8'd0;
					started_d = 1'b0;
					elapsed_d = 32'd0;
					status    = kpl_pkg::ST_VALID;
				end else if (started_q) begin
					// Last try after cooldown failed
					lockout_d = 1'b1;
					status    = kpl_pkg::ST_INVALID;
				end else begin
					fail_d = fail_inc;
					if (fail_inc >= cfg.max_attempts) begin
						started_d = 1'b1;
						elapsed_d = 32'd0;
					end
					status = kpl_pkg::ST_INVALID;
				end
			end
		end else if (is_digit && (count_q < CW'(CODE_DIGITS))) begin
			digit_we = 1'b1;
			count_d  = count_q + CW'(1);
		end
	end

	always_comb begin
		result.status          = status;
		result.entered_count   = 3'(count_d);
		result.locked          = lockout_d;
		result.cooldown_active = started_d && (elapsed_d < cfg.cooldown_ticks);
		result.fail_count      = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			fail_q    <= 8'd0;
			started_q <= 1'b0;
			elapsed_q <= 32'd0;
			lockout_q <= 1'b0;
		end else if (step) begin
			count_q   <= count_d;
			fail_q    <= fail_d;
			started_q <= started_d;
			elapsed_q <= elapsed_d;
			lockout_q <= lockout_d;
		end
	end

	// Entry digits hold no reset; only a full entry is ever compared
	always_ff @(posedge clk) begin
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (step && digit_we && (count_q == CW'(i))) begin
				entry_q[i] <= digit_val;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/keypad_passcode_lock.sv =====
`default_nettype none

// Keypad passcode lock.
// Slave stream: one transaction per key press or time tick. tuser selects
// the kind (0 key, 1 tick), tdata carries the key code.
// Master stream: exactly one result transaction per input transaction, in
// order: status, digits entered, locked flag, cooldown flag, failure count.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// write only while no transaction is in flight.
// An accepted input waits in the input stage, then its result is registered
// in the output register. Throughput is one transaction per cycle unless the
// master side stalls; the state update is a single compare-and-update step
// between the stages, and the 32-bit cooldown compare sets the longest path.
// When the master side stalls, the output register holds its result and an
// empty input stage takes one more transaction before s_tready drops.
// Reset clears the entry, counters, cooldown and lockout, and restores the
// configuration defaults; only reset leaves a lockout.

module keypad_passcode_lock #(
	parameter int unsigned CODE_DIGITS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // [7:0] key_code
	input  wire logic                              s_tuser,  // [0] op
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [2:0] status, [5:3] entered_count, [6] locked, [7] cooldown_active,
	// [15:8] fail_count
	output logic [15:0]                            m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [kpl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [kpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	kpl_pkg::kpl_cfg_t    cfg_q;
	kpl_pkg::kpl_result_t result;

	logic             valid_s1;
	kpl_pkg::kpl_op_t op_s1;
	logic [7:0]       key_s1;
	logic             m_valid_q;
	logic [15:0]      m_data_q;
	logic             advance;
	logic             step;

	assign advance  = !m_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.secret_digits  <= kpl_pkg::SECRET_RST;
			cfg_q.max_attempts   <= kpl_pkg::MAX_ATTEMPTS_RST;
			cfg_q.cooldown_ticks <= kpl_pkg::COOLDOWN_RST;
			cfg_q.pop_key        <= kpl_pkg::POP_KEY_RST;
			cfg_q.validate_key   <= kpl_pkg::VALIDATE_KEY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kpl_pkg::REG_SECRET:       cfg_q.secret_digits  <= cfg_data[15:0];
				kpl_pkg::REG_MAX_ATTEMPTS: cfg_q.max_attempts   <= cfg_data[7:0];
				kpl_pkg::REG_COOLDOWN:     cfg_q.cooldown_ticks <= cfg_data[31:0];
				kpl_pkg::REG_POP_KEY:      cfg_q.pop_key        <= cfg_data[7:0];
				kpl_pkg::REG_VALIDATE_KEY: cfg_q.validate_key   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= kpl_pkg::kpl_op_t'(s_tuser);
			key_s1 <= s_tdata;
		end
		if (step) begin
			m_data_q <= {result.fail_count, result.cooldown_active, result.locked,
				result.entered_count, result.status};
		end
	end

	kpl_core #(
		.CODE_DIGITS (CODE_DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.step     (step),
		.op       (op_s1),
		.key_code (key_s1),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== design/kpl_checker.sv =====
`default_nettype none

module kpl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// Stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A require-reset refusal always carries the locked flag
	a_locked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == kpl_pkg::ST_REQUIRE_RESET) |-> m_tdata[6])
		else $error("require-reset without lockout");

	// Cooldown refusal clears the entry and is not a lockout
	a_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == kpl_pkg::ST_COOLDOWN)
		|-> (m_tdata[5:3] == 3'd0) && !m_tdata[6] && m_tdata[7])
		else $error("cooldown status with wrong flags");

	// Success clears the counters
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == kpl_pkg::ST_VALID)
		|-> (m_tdata[15:8] == 8'd0) && !m_tdata[7] && !m_tdata[6] && (m_tdata[5:3] == 3'd0))
		else $error("valid status did not clear counters");

endmodule

bind keypad_passcode_lock kpl_checker u_kpl_checker (.*);

`default_nettype wire

// ===== tb/sv/keypad_passcode_lock_test.sv =====
`timescale 1ns / 100ps

module keypad_passcode_lock_test;

	localparam int ENTRY_LEN       = kpl_pkg::SECRET_DIGITS;
	localparam int PHASES          = 10;
	localparam int PHASE_ITEMS     = 102;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 1500;

	typedef struct packed {
		logic [15:0] digits;    // entered digit i in nibble i
		logic [2:0]  count;
		logic [7:0]  failures;
		logic        cd_started;
		logic [31:0] elapsed;
		logic        lockout;
	} lock_state_t;

	typedef struct {
		bit                   is_write;
		kpl_pkg::kpl_reg_t    idx;
		logic [31:0]          value;
		kpl_pkg::kpl_op_t     op;
		logic [7:0]           key;
		bit                   typed;
		kpl_pkg::kpl_result_t want;
	} plan_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;   // [7:0] key_code
	logic        s_tuser   = 1'b0;   // [0] op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// [2:0] status, [5:3] entered_count, [6] locked, [7] cooldown_active,
	// [15:8] fail_count
	logic [15:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [kpl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [kpl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	kpl_pkg::kpl_cfg_t lock_cfg = '{secret_digits: kpl_pkg::SECRET_RST,
		max_attempts: kpl_pkg::MAX_ATTEMPTS_RST, cooldown_ticks: kpl_pkg::COOLDOWN_RST,
		pop_key: kpl_pkg::POP_KEY_RST, validate_key: kpl_pkg::VALIDATE_KEY_RST};
	lock_state_t lock_st = '0;
	kpl_pkg::kpl_result_t expected_q[$];
	plan_row_t   plan[$];

	int unsigned items_sent   = 0;
	int unsigned fault_count  = 0;
	int unsigned stuck_cycles = 0;
	bit          sender_idles = 1'b1;
	bit          lock_ok      = 1'b0;
	bit          hold_off_done = 1'b0;
	logic        hold_off_req = 1'b0;
	logic        quiet        = 1'b0;

	keypad_passcode_lock DUT (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_we, .cfg_index, .cfg_data
	);

	always #10 clk = ~clk;

	function automatic bit cooling(lock_state_t s, kpl_pkg::kpl_cfg_t c);
		return s.cd_started && (s.elapsed < c.cooldown_ticks);
	endfunction

	// Advance the lock by one key press or tick and return its response
	function automatic kpl_pkg::kpl_result_t lock_step(inout lock_state_t s,
		input kpl_pkg::kpl_cfg_t c, input kpl_pkg::kpl_op_t op, input logic [7:0] key);
		kpl_pkg::kpl_result_t r;
		kpl_pkg::kpl_status_t st;
		st = kpl_pkg::ST_OK;
		if (op == kpl_pkg::OP_TICK) begin
			if (cooling(s, c))
				s.elapsed++;
		end else if (s.lockout)
			st = kpl_pkg::ST_REQUIRE_RESET;
		else if (cooling(s, c)) begin
			s.count = 3'd0;
			st = kpl_pkg::ST_COOLDOWN;
		end else if (key == c.pop_key) begin
			if (s.count != 3'd0)
				s.count--;
		end else if (key == c.validate_key) begin
			if (s.count != ENTRY_LEN)
				st = kpl_pkg::ST_INCOMPLETE;
			else begin
				s.count = 3'd0;
				if (s.digits == c.secret_digits) begin
					s.failures = 8'd0;
					s.cd_started = 1'b0;
					s.elapsed = 32'd0;
					st = kpl_pkg::ST_VALID;
				end else begin
					st = kpl_pkg::ST_INVALID;
					// the try after a cooldown is the last one
					if (s.cd_started)
						s.lockout = 1'b1;
					else begin
						if (s.failures != 8'hFF)
							s.failures++;
						if (s.failures >= c.max_attempts) begin
							s.cd_started = 1'b1;
							s.elapsed = 32'd0;
						end
					end
				end
			end
		end else if (key >= kpl_pkg::KEY_ZERO && key <= kpl_pkg::KEY_NINE &&
			s.count < ENTRY_LEN) begin
			s.digits[4*s.count +: 4] = 4'(key - kpl_pkg::KEY_ZERO);
			s.count++;
		end
		r.status = st;
		r.entered_count = s.count;
		r.locked = s.lockout;
		r.cooldown_active = cooling(s, c);
		r.fail_count = s.failures;
		return r;
	endfunction

	function automatic kpl_pkg::kpl_result_t plain_result(kpl_pkg::kpl_status_t st,
		logic [2:0] cnt);
		kpl_pkg::kpl_result_t r;
		r = '0;
		r.status = st;
		r.entered_count = cnt;
		return r;
	endfunction

	function automatic void plan_item(kpl_pkg::kpl_op_t op, logic [7:0] key);
		plan.push_back('{1'b0, kpl_pkg::REG_SECRET, 32'd0, op, key, 1'b0,
			kpl_pkg::kpl_result_t'('0)});
	endfunction

	function automatic void plan_typed(kpl_pkg::kpl_op_t op, logic [7:0] key,
		kpl_pkg::kpl_result_t want);
		plan.push_back('{1'b0, kpl_pkg::REG_SECRET, 32'd0, op, key, 1'b1, want});
	endfunction

	function automatic void plan_write(kpl_pkg::kpl_reg_t idx, logic [31:0] value);
		plan.push_back('{1'b1, idx, value, kpl_pkg::OP_KEY, 8'd0, 1'b0,
			kpl_pkg::kpl_result_t'('0)});
	endfunction

	function automatic void flag_error(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	task automatic write_reg(kpl_pkg::kpl_reg_t idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			kpl_pkg::REG_SECRET:       lock_cfg.secret_digits = value[15:0];
			kpl_pkg::REG_MAX_ATTEMPTS: lock_cfg.max_attempts = value[7:0];
			kpl_pkg::REG_COOLDOWN:     lock_cfg.cooldown_ticks = value;
			kpl_pkg::REG_POP_KEY:      lock_cfg.pop_key = value[7:0];
			kpl_pkg::REG_VALIDATE_KEY: lock_cfg.validate_key = value[7:0];
			default: ;
		endcase
	endtask

	// Drop valid and hold until every response is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic drive_item(kpl_pkg::kpl_op_t op, logic [7:0] key, bit typed = 1'b0,
		kpl_pkg::kpl_result_t want = '0);
		kpl_pkg::kpl_result_t predicted;
		if (sender_idles && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= key;
		do @(posedge clk); while (!s_tready);
		predicted = lock_step(lock_st, lock_cfg, op, key);
		expected_q.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Key press that turns into a tick if it would lock the block too early
	task automatic press(logic [7:0] key);
		lock_state_t trial;
		trial = lock_st;
		void'(lock_step(trial, lock_cfg, kpl_pkg::OP_KEY, key));
		if (trial.lockout && !lock_st.lockout && !lock_ok)
			drive_item(kpl_pkg::OP_TICK, key);
		else
			drive_item(kpl_pkg::OP_KEY, key);
	endtask

	task automatic try_code();
		logic [15:0] code;
		bit usable, last_try;
		int i, n_digits;
		usable = 1'b1;
		for (i = 0; i < ENTRY_LEN; i++)
			if (lock_cfg.secret_digits[4*i +: 4] > 4'd9)
				usable = 1'b0;
		last_try = lock_st.cd_started && !cooling(lock_st, lock_cfg);
		if (usable && ((last_try && !lock_ok) || $urandom_range(0, 2) == 0))
			code = lock_cfg.secret_digits;
		else
			for (i = 0; i < ENTRY_LEN; i++)
				code[4*i +: 4] = 4'($urandom_range(0, 9));
		repeat (lock_st.count) press(lock_cfg.pop_key);
		n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ENTRY_LEN - 1) : ENTRY_LEN;
		for (i = 0; i < n_digits; i++) begin
			if ($urandom_range(0, 9) == 0)
				drive_item(kpl_pkg::OP_TICK, 8'($urandom));
			if ($urandom_range(0, 9) == 0) begin
				press(kpl_pkg::KEY_ZERO + 8'($urandom_range(0, 9)));
				press(lock_cfg.pop_key);
			end
			press(kpl_pkg::KEY_ZERO + {4'd0, code[4*i +: 4]});
		end
		press(lock_cfg.validate_key);
	endtask

	task automatic pick_settings(int ph);
		logic [15:0] secret;
		logic [7:0]  tries, popk, valk;
		logic [31:0] span;
		int i;
		for (i = 0; i < ENTRY_LEN; i++)
			secret[4*i +: 4] = 4'($urandom_range(0, 9));
		tries = 8'($urandom_range(1, 5));
		span = 32'($urandom_range(0, 12));
		popk = kpl_pkg::POP_KEY_RST;
		valk = kpl_pkg::VALIDATE_KEY_RST;
		case (ph)
			1: tries = 8'd255;
			2: begin
				// unreachable secret and a cooldown that never ends
				secret = 16'hFFFF;
				tries = 8'd0;
				span = 32'hFFFF_FFFF;
				popk = 8'h00;
				valk = 8'hFF;
			end
			3: begin
				span = 32'd0;
				popk = 8'hFF;
				valk = 8'h00;
			end
			4: begin
				secret[7:4] = 4'hB;
				tries = 8'd4;
				popk = 8'($urandom);
				valk = 8'($urandom);
			end
			5: begin
				secret = 16'h9999;
				tries = 8'd2;
				span = 32'd1;
			end
			6: begin
				secret = 16'h0000;
				popk = 8'($urandom);
				valk = popk;
			end
			PHASES - 1: begin
				tries = 8'd1;
				span = 32'd3;
			end
			default: ;
		endcase
		write_reg(kpl_pkg::REG_SECRET, {16'd0, secret});
		write_reg(kpl_pkg::REG_MAX_ATTEMPTS, {24'd0, tries});
		write_reg(kpl_pkg::REG_COOLDOWN, span);
		write_reg(kpl_pkg::REG_POP_KEY, {24'd0, popk});
		write_reg(kpl_pkg::REG_VALIDATE_KEY, {24'd0, valk});
	endtask

	always @(posedge clk) begin : result_check
		kpl_pkg::kpl_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = kpl_pkg::kpl_result_t'(m_tdata);
			if (expected_q.size() == 0)
				flag_error($sformatf("response %h with nothing outstanding", m_tdata));
			else begin
				want = expected_q.pop_front();
				if (got.status !== want.status || got.entered_count !== want.entered_count ||
					got.locked !== want.locked || got.cooldown_active !== want.cooldown_active ||
					got.fail_count !== want.fail_count)
					flag_error($sformatf({"status %0d/%0d count %0d/%0d locked %0b/%0b ",
						"cooldown %0b/%0b fails %0d/%0d (expected/actual)"},
						want.status, got.status, want.entered_count, got.entered_count,
						want.locked, got.locked, want.cooldown_active, got.cooldown_active,
						want.fail_count, got.fail_count));
			end
		end
	end

	always @(posedge clk)
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;

	initial begin : watchdog
		wait (stuck_cycles >= WATCHDOG_LIMIT);
		$display("keypad_passcode_lock_test: done, errors");
		$finish;
	end

	initial begin : sink_pacing
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				// long stall so the block backs up into its input
				hold_off_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet) begin
				n = $urandom_range(0, 19);
				if (n == 0) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 13)) @(posedge clk);
					m_tready <= 1'b1;
				end else if (n == 1)
					repeat ($urandom_range(30, 120)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int ph, pick;
		int unsigned phase_end;
		logic [7:0] noise_key;

		// after reset: defaults, pop on empty, partial validate, non-digits
		plan_typed(kpl_pkg::OP_TICK, 8'hA5, plain_result(kpl_pkg::ST_OK, 3'd0));
		plan_typed(kpl_pkg::OP_KEY, kpl_pkg::VALIDATE_KEY_RST,
			plain_result(kpl_pkg::ST_INCOMPLETE, 3'd0));
		plan_typed(kpl_pkg::OP_KEY, kpl_pkg::POP_KEY_RST, plain_result(kpl_pkg::ST_OK, 3'd0));
		plan_typed(kpl_pkg::OP_KEY, 8'h00, plain_result(kpl_pkg::ST_OK, 3'd0));
		plan_typed(kpl_pkg::OP_KEY, 8'hFF, plain_result(kpl_pkg::ST_OK, 3'd0));
		plan_typed(kpl_pkg::OP_KEY, kpl_pkg::KEY_NINE + 8'd1,
			plain_result(kpl_pkg::ST_OK, 3'd0));
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_NINE);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::POP_KEY_RST);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::VALIDATE_KEY_RST);
		// secret with a non-decimal nibble, zero attempts, short cooldown
		plan_write(kpl_pkg::REG_SECRET, 32'h0000_00A9);
		plan_write(kpl_pkg::REG_MAX_ATTEMPTS, 32'd0);
		plan_write(kpl_pkg::REG_COOLDOWN, 32'd2);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd9);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd8);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd7);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd5);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::VALIDATE_KEY_RST);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd1);
		plan_item(kpl_pkg::OP_TICK, 8'h5A);
		plan_item(kpl_pkg::OP_TICK, 8'h00);
		plan_item(kpl_pkg::OP_TICK, 8'hFF);
		// last try after the cooldown succeeds
		plan_write(kpl_pkg::REG_SECRET, 32'h0000_4321);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd1);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd2);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd3);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd4);
		plan_typed(kpl_pkg::OP_KEY, kpl_pkg::VALIDATE_KEY_RST,
			plain_result(kpl_pkg::ST_VALID, 3'd0));
		// pop and validate on one code: pop wins
		plan_write(kpl_pkg::REG_VALIDATE_KEY, {24'd0, kpl_pkg::POP_KEY_RST});
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::KEY_ZERO + 8'd5);
		plan_item(kpl_pkg::OP_KEY, kpl_pkg::POP_KEY_RST);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				settle();
				write_reg(plan[i].idx, plan[i].value);
			end else
				drive_item(plan[i].op, plan[i].key, plan[i].typed, plan[i].want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			pick_settings(ph);
			sender_idles = (ph != PHASES - 1) && (ph % 4 != 3);
			if (ph == 1)
				hold_off_req <= 1'b1;
			if (ph == PHASES - 1) begin
				quiet <= 1'b1;
				lock_ok = 1'b1;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (cooling(lock_st, lock_cfg) && pick < 70)
					repeat ($urandom_range(1, 8)) drive_item(kpl_pkg::OP_TICK, 8'($urandom));
				else if (pick < 60)
					try_code();
				else if (pick < 75)
					repeat ($urandom_range(1, 4)) drive_item(kpl_pkg::OP_TICK, 8'($urandom));
				else
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 3))
							0: noise_key = 8'($urandom);
							1: noise_key = kpl_pkg::KEY_ZERO + 8'($urandom_range(0, 9));
							2: noise_key = lock_cfg.pop_key;
							default: noise_key = lock_cfg.validate_key;
						endcase
						if ($urandom_range(0, 4) == 0)
							drive_item(kpl_pkg::OP_TICK, noise_key);
						else
							press(noise_key);
					end
			end
		end

		settle();
		if (fault_count == 0)
			$display("keypad_passcode_lock_test: done, clean");
		else
			$display("keypad_passcode_lock_test: done, errors");
		$finish;
	end

endmodule
